/* rtl/core/mss_pkg.sv */
package mss_pkg;

  localparam int SAMPLE_W    = 24;
  localparam int COEFF_W     = 24;
  localparam int ACC_W       = 32;
  localparam int GAIN_W      = 24;
  localparam int TGT_W       = 16;
  localparam int PAN_W       = 16;
  localparam int LEVEL_W     = 16;
  localparam int LVL_W       = 17;
  localparam int BAND_COUNT  = 6;
  localparam int SPLIT_COUNT = 5;
  localparam int IDX_W       = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int MUL_A_W     = 34;
  localparam int MUL_B_W     = 25;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;
  localparam int SUM_W       = 61;
  localparam int SQ_W        = 32;
  localparam int SQ_STEPS    = 16;
  localparam int CNT_W       = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH = 3'd5;

  localparam logic [LVL_W-1:0]   LEVEL_ONE    = 17'd32768;
  localparam logic [TGT_W-1:0]   TARGET_RESET = 16'd23170;
  localparam logic [GAIN_W-1:0]  GAIN_RESET   = 24'd5931642;
  localparam logic [COEFF_W-1:0] SMOOTH_RESET = 24'd116100;
  localparam logic [COEFF_W-1:0] COEFF_RESET [SPLIT_COUNT] =
    '{24'd261471, 24'd751300, 24'd2058600, 24'd5148400, 24'd10889800};

  typedef enum logic [3:0] {
    CMD_NONE    = 4'd0,
    CMD_LOAD    = 4'd1,
    CMD_LP_MUL  = 4'd2,
    CMD_LP_ACC  = 4'd3,
    CMD_GL_MUL  = 4'd4,
    CMD_GL_UPD  = 4'd5,
    CMD_BD_MUL  = 4'd6,
    CMD_BD_ACC  = 4'd7,
    CMD_SQ_INIT = 4'd8,
    CMD_SQ_STEP = 4'd9,
    CMD_TG_MUL  = 4'd10,
    CMD_TG_WR   = 4'd11,
    CMD_OUT     = 4'd12
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t          op;
    logic [IDX_W-1:0] idx;
    logic             side;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

/* rtl/core/multiband_stereo_spreader_top.sv */
// a sample request runs the low-pass splits, gain smoothing and band sums,
// then raises out_valid once the output is free; a new request waits
// until then; a band control request updates both side targets, and
// an out-of-range band is taken every cycle; work is paced by the single
// shared multiplier and the bit-pair square root (16 steps per side)
// synchronous active-high reset restores coefficients, gains, filter state
module multiband_stereo_spreader_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [mss_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mss_pkg::COEFF_W-1:0]         cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                op,
  input  logic signed [mss_pkg::SAMPLE_W-1:0] sample_left,
  input  logic signed [mss_pkg::SAMPLE_W-1:0] sample_right,
  input  logic [mss_pkg::IDX_W-1:0]           band_index,
  input  logic signed [mss_pkg::PAN_W-1:0]    pan_value,
  input  logic [mss_pkg::LEVEL_W-1:0]         level_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [mss_pkg::SAMPLE_W-1:0] out_left,
  output logic signed [mss_pkg::SAMPLE_W-1:0] out_right
);

  mss_pkg::cmd_t  cmd;
  mss_pkg::stat_t stat;

  mss_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .band_index (band_index),
    .stat       (stat),
    .cmd        (cmd)
  );

  mss_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_left  (sample_left),
    .sample_right (sample_right),
    .pan_value    (pan_value),
    .level_value  (level_value),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_left     (out_left),
    .out_right    (out_right)
  );

`ifndef ASSERT_OFF
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready &&
    (!op || band_index < mss_pkg::IDX_W'(mss_pkg::BAND_COUNT)) |=> !in_ready)
    else $error("request accepted while busy");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.op == mss_pkg::CMD_OUT |-> (!out_valid || out_ready))
    else $error("result overwritten before taken");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.op == mss_pkg::CMD_OUT))
    else $error("result without output command");
`endif

endmodule

/* rtl/core/mss_datapath.sv */
module mss_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [mss_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mss_pkg::COEFF_W-1:0]         cfg_data,
  input  logic signed [mss_pkg::SAMPLE_W-1:0] sample_left,
  input  logic signed [mss_pkg::SAMPLE_W-1:0] sample_right,
  input  logic signed [mss_pkg::PAN_W-1:0]    pan_value,
  input  logic [mss_pkg::LEVEL_W-1:0]         level_value,
  input  mss_pkg::cmd_t                       cmd,
  output mss_pkg::stat_t                      stat,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [mss_pkg::SAMPLE_W-1:0] out_left,
  output logic signed [mss_pkg::SAMPLE_W-1:0] out_right
);

  logic [mss_pkg::COEFF_W-1:0] coeff [mss_pkg::SPLIT_COUNT];
  logic [mss_pkg::COEFF_W-1:0] smooth;
  logic signed [mss_pkg::ACC_W-1:0] acc [mss_pkg::SPLIT_COUNT];
  logic [mss_pkg::TGT_W-1:0] tgt_l [mss_pkg::BAND_COUNT];
  logic [mss_pkg::TGT_W-1:0] tgt_r [mss_pkg::BAND_COUNT];
  logic [mss_pkg::GAIN_W-1:0] g_l [mss_pkg::BAND_COUNT];
  logic [mss_pkg::GAIN_W-1:0] g_r [mss_pkg::BAND_COUNT];

  logic signed [mss_pkg::ACC_W-1:0]  mono;
  logic signed [mss_pkg::ACC_W-1:0]  acc_prev;
  logic [mss_pkg::LVL_W-1:0]         lvl;
  logic signed [mss_pkg::PAN_W-1:0]  pan;
  logic signed [mss_pkg::PROD_W-1:0] prod;
  logic signed [mss_pkg::SUM_W-1:0]  sum_l;
  logic signed [mss_pkg::SUM_W-1:0]  sum_r;
  logic [mss_pkg::SQ_W-1:0]          rem;
  logic [mss_pkg::SQ_W-1:0]          root;
  logic [mss_pkg::SQ_W-1:0]          sbit;

  logic signed [mss_pkg::ACC_W-1:0]   acc_sel;
  logic [mss_pkg::GAIN_W-1:0]         g_sel;
  logic [mss_pkg::TGT_W-1:0]          t_sel;
  logic signed [mss_pkg::ACC_W:0]     lp_diff;
  logic signed [mss_pkg::GAIN_W:0]    gl_diff;
  logic signed [mss_pkg::ACC_W:0]     band;
  logic signed [mss_pkg::MUL_A_W-1:0] mul_a;
  logic signed [mss_pkg::MUL_B_W-1:0] mul_b;
  logic signed [mss_pkg::PROD_W-1:0]  mul_p;
  logic signed [mss_pkg::SAMPLE_W:0]  in_sum;
  logic signed [mss_pkg::SAMPLE_W:0]  in_half;
  logic signed [mss_pkg::PROD_W-25:0] prod_q24;
  logic signed [mss_pkg::ACC_W+1:0]   lp_new;
  logic signed [mss_pkg::GAIN_W+1:0]  g_new;
  logic signed [17:0]                 pan_x;
  logic [mss_pkg::SQ_W-1:0]           sq_u;
  logic [mss_pkg::SQ_W-1:0]           sq_trial;

  function automatic logic signed [mss_pkg::SAMPLE_W-1:0] sat_out(
    input logic signed [mss_pkg::SUM_W-1:0] s
  );
    logic signed [mss_pkg::SUM_W-1:0] sh;
    sh = s >>> 31;
    if (sh > mss_pkg::SUM_W'(8388607)) begin
      return 24'sh7fffff;
    end else if (sh < -mss_pkg::SUM_W'(8388608)) begin
      return 24'sh800000;
    end
    return sh[mss_pkg::SAMPLE_W-1:0];
  endfunction

  always_comb begin
    acc_sel  = (cmd.idx < mss_pkg::IDX_W'(mss_pkg::SPLIT_COUNT)) ? acc[cmd.idx] : mono;
    g_sel    = cmd.side ? g_r[cmd.idx] : g_l[cmd.idx];
    t_sel    = cmd.side ? tgt_r[cmd.idx] : tgt_l[cmd.idx];
    lp_diff  = 33'(mono) - 33'(acc_sel);
    gl_diff  = $signed({1'b0, t_sel, 8'b0}) - $signed({1'b0, g_sel});
    band     = 33'(acc_sel) - ((cmd.idx == '0) ? 33'sd0 : 33'(acc_prev));
    in_sum   = 25'(sample_left) + 25'(sample_right);
    in_half  = in_sum >>> 1;
    prod_q24 = prod[mss_pkg::PROD_W-1:24];
    lp_new   = 34'(acc_sel) + 34'(prod_q24);
    g_new    = $signed({2'b0, g_sel}) + 26'(prod_q24);
    pan_x    = cmd.side ? (18'sd32768 + 18'(pan)) : (18'sd32768 - 18'(pan));
    sq_u     = {1'b0, pan_x[16:0], 14'b0};
    sq_trial = root + sbit;
    case (cmd.op)
      mss_pkg::CMD_LP_MUL: begin
        mul_a = 34'(lp_diff);
        mul_b = $signed({1'b0, coeff[cmd.idx[2:0]]});
      end
      mss_pkg::CMD_GL_MUL: begin
        mul_a = 34'(gl_diff);
        mul_b = $signed({1'b0, smooth});
      end
      mss_pkg::CMD_BD_MUL: begin
        mul_a = 34'(band);
        mul_b = $signed({1'b0, g_sel});
      end
      mss_pkg::CMD_TG_MUL: begin
        mul_a = $signed({17'b0, lvl});
        mul_b = $signed({8'b0, root[16:0]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mss_pkg::SPLIT_COUNT; i++) begin
        coeff[i] <= mss_pkg::COEFF_RESET[i];
        acc[i]   <= '0;
      end
      for (int i = 0; i < mss_pkg::BAND_COUNT; i++) begin
        tgt_l[i] <= mss_pkg::TARGET_RESET;
        tgt_r[i] <= mss_pkg::TARGET_RESET;
        g_l[i]   <= mss_pkg::GAIN_RESET;
        g_r[i]   <= mss_pkg::GAIN_RESET;
      end
      smooth    <= mss_pkg::SMOOTH_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        if (cfg_index < mss_pkg::CFG_IDX_W'(mss_pkg::SPLIT_COUNT)) begin
          coeff[cfg_index] <= cfg_data;
        end else if (cfg_index == mss_pkg::CFG_SMOOTH) begin
          smooth <= cfg_data;
        end
      end
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        mss_pkg::CMD_LP_ACC: begin
          if (lp_new > 34'sh07fffffff) begin
            acc[cmd.idx] <= 32'sh7fffffff;
          end else if (lp_new < -34'sh080000000) begin
            acc[cmd.idx] <= 32'sh80000000;
          end else begin
            acc[cmd.idx] <= lp_new[mss_pkg::ACC_W-1:0];
          end
        end
        mss_pkg::CMD_GL_UPD: begin
          if (cmd.side) begin
            g_r[cmd.idx] <= g_new[mss_pkg::GAIN_W-1:0];
          end else begin
            g_l[cmd.idx] <= g_new[mss_pkg::GAIN_W-1:0];
          end
        end
        mss_pkg::CMD_TG_WR: begin
          if (cmd.side) begin
            tgt_r[cmd.idx] <= prod[30:15];
          end else begin
            tgt_l[cmd.idx] <= prod[30:15];
          end
        end
        mss_pkg::CMD_OUT: begin
          out_valid <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      mss_pkg::CMD_LOAD: begin
        mono     <= {in_half[mss_pkg::SAMPLE_W-1:0], 8'b0};
        lvl      <= ({1'b0, level_value} > mss_pkg::LEVEL_ONE) ?
                    mss_pkg::LEVEL_ONE : {1'b0, level_value};
        pan      <= pan_value;
        sum_l    <= '0;
        sum_r    <= '0;
        acc_prev <= '0;
      end
      mss_pkg::CMD_LP_MUL, mss_pkg::CMD_GL_MUL, mss_pkg::CMD_BD_MUL,
      mss_pkg::CMD_TG_MUL: begin
        prod <= mul_p;
      end
      mss_pkg::CMD_BD_ACC: begin
        if (cmd.side) begin
          sum_r <= sum_r + mss_pkg::SUM_W'(prod);
          acc_prev <= acc_sel;
        end else begin
          sum_l <= sum_l + mss_pkg::SUM_W'(prod);
        end
      end
      mss_pkg::CMD_SQ_INIT: begin
        rem  <= sq_u;
        root <= '0;
        sbit <= 32'h4000_0000;
      end
      mss_pkg::CMD_SQ_STEP: begin
        if (rem >= sq_trial) begin
          rem  <= rem - sq_trial;
          root <= (root >> 1) + sbit;
        end else begin
          root <= root >> 1;
        end
        sbit <= sbit >> 2;
      end
      mss_pkg::CMD_OUT: begin
        out_left  <= sat_out(sum_l);
        out_right <= sat_out(sum_r);
      end
      default: begin
      end
    endcase
  end

endmodule

/* rtl/core/mss_ctrl.sv */
module mss_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      op,
  input  logic [mss_pkg::IDX_W-1:0] band_index,
  input  mss_pkg::stat_t            stat,
  output mss_pkg::cmd_t             cmd
);

  typedef enum logic [11:0] {
    ST_IDLE = 12'b000000000001,
    ST_LPM  = 12'b000000000010,
    ST_LPA  = 12'b000000000100,
    ST_GLM  = 12'b000000001000,
    ST_GLA  = 12'b000000010000,
    ST_BDM  = 12'b000000100000,
    ST_BDA  = 12'b000001000000,
    ST_OUT  = 12'b000010000000,
    ST_SQI  = 12'b000100000000,
    ST_SQS  = 12'b001000000000,
    ST_TGM  = 12'b010000000000,
    ST_TGA  = 12'b100000000000
  } state_t;

  state_t                    state, state_next;
  logic [mss_pkg::IDX_W-1:0] idx, idx_next;
  logic                      side, side_next;
  logic [mss_pkg::CNT_W-1:0] cnt, cnt_next;

  always_comb begin
    state_next = state;
    idx_next   = idx;
    side_next  = side;
    cnt_next   = cnt;
    in_ready   = 1'b0;
    cmd.op     = mss_pkg::CMD_NONE;
    cmd.idx    = idx;
    cmd.side   = side;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = mss_pkg::CMD_LOAD;
          side_next = 1'b0;
          if (op) begin
            if (band_index < mss_pkg::IDX_W'(mss_pkg::BAND_COUNT)) begin
              idx_next   = band_index;
              state_next = ST_SQI;
            end
          end else begin
            idx_next   = '0;
            state_next = ST_LPM;
          end
        end
      end
      ST_LPM: begin
        cmd.op     = mss_pkg::CMD_LP_MUL;
        state_next = ST_LPA;
      end
      ST_LPA: begin
        cmd.op = mss_pkg::CMD_LP_ACC;
        if (idx == mss_pkg::IDX_W'(mss_pkg::SPLIT_COUNT - 1)) begin
          idx_next   = '0;
          state_next = ST_GLM;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = ST_LPM;
        end
      end
      ST_GLM: begin
        cmd.op     = mss_pkg::CMD_GL_MUL;
        state_next = ST_GLA;
      end
      ST_GLA: begin
        cmd.op     = mss_pkg::CMD_GL_UPD;
        side_next  = !side;
        state_next = side ? ST_BDM : ST_GLM;
      end
      ST_BDM: begin
        cmd.op     = mss_pkg::CMD_BD_MUL;
        state_next = ST_BDA;
      end
      ST_BDA: begin
        cmd.op    = mss_pkg::CMD_BD_ACC;
        side_next = !side;
        if (!side) begin
          state_next = ST_BDM;
        end else if (idx == mss_pkg::IDX_W'(mss_pkg::BAND_COUNT - 1)) begin
          state_next = ST_OUT;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = ST_GLM;
        end
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.op     = mss_pkg::CMD_OUT;
          state_next = ST_IDLE;
        end
      end
      ST_SQI: begin
        cmd.op     = mss_pkg::CMD_SQ_INIT;
        cnt_next   = '0;
        state_next = ST_SQS;
      end
      ST_SQS: begin
        cmd.op   = mss_pkg::CMD_SQ_STEP;
        cnt_next = cnt + 1'b1;
        if (cnt == mss_pkg::CNT_W'(mss_pkg::SQ_STEPS - 1)) begin
          state_next = ST_TGM;
        end
      end
      ST_TGM: begin
        cmd.op     = mss_pkg::CMD_TG_MUL;
        state_next = ST_TGA;
      end
      ST_TGA: begin
        cmd.op     = mss_pkg::CMD_TG_WR;
        side_next  = !side;
        state_next = side ? ST_IDLE : ST_SQI;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
      side  <= 1'b0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      side  <= side_next;
      cnt   <= cnt_next;
    end
  end

endmodule
